>>> src/vsme_pkg.sv
// Shared types, command codes and half-bit tables of the subcarrier Manchester encoder.
package vsme_pkg;

   typedef enum logic [1:0] {
      CMD_SOF  = 2'd0,
      CMD_DATA = 2'd1,
      CMD_EOF  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   localparam logic [15:0] SEG_SILENCE    = 16'h0000;
   localparam logic [15:0] SEG_SUBCARRIER = 16'h5555;

   // Half-bit sequences, first half in bit 0; a 1 means a subcarrier half.
   localparam logic [15:0] SOF_HALVES = 16'b0000_0000_1011_1000;
   localparam logic [15:0] EOF_HALVES = 16'b0000_0000_0001_1101;

   localparam logic [4:0] FRAME_HALF_COUNT = 5'd8;
   localparam logic [4:0] BYTE_HALF_COUNT  = 5'd16;

   typedef struct packed {
      logic [15:0] pattern;
      logic        last;
   } seg_type;

   // A one bit is silence then subcarrier, a zero bit the reverse, LSB first.
   function automatic logic [15:0] byte_halves(input logic [7:0] data);
      logic [15:0] halves;
      for (int i = 0; i < 8; i++) begin
         halves[2*i]   = ~data[i];
         halves[2*i+1] = data[i];
      end
      return halves;
   endfunction

endpackage

>>> src/vsme_sequencer.sv
// Half-bit shift register and repeat counter that step out one segment per cycle unless stalled.
module vsme_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 low_rate,
   input  logic                 start,
   input  logic [15:0]          halves,
   input  logic [4:0]           half_count,
   output logic                 busy,
   output logic                 seg_valid,
   input  logic                 seg_ready,
   output vsme_pkg::seg_type    seg
);
   import vsme_pkg::*;

   logic [15:0] halves_ff, halves_in;
   logic [4:0]  left_ff, left_in;
   logic [1:0]  rep_ff, rep_in;
   logic        active_ff, active_in;
   logic [1:0]  rep_max;
   logic        half_done;

   assign rep_max     = low_rate ? 2'd3 : 2'd0;
   assign half_done   = (rep_ff == rep_max);
   assign busy        = active_ff;
   assign seg_valid   = active_ff;
   assign seg.pattern = halves_ff[0] ? SEG_SUBCARRIER : SEG_SILENCE;
   assign seg.last    = half_done && (left_ff == 5'd1);

   always_comb begin
      halves_in = halves_ff;
      left_in   = left_ff;
      rep_in    = rep_ff;
      active_in = active_ff;
      if (start) begin
         halves_in = halves;
         left_in   = half_count;
         rep_in    = 2'd0;
         active_in = 1'b1;
      end else if (active_ff && seg_ready) begin
         if (half_done) begin
            rep_in    = 2'd0;
            halves_in = {1'b0, halves_ff[15:1]};
            left_in   = left_ff - 5'd1;
            if (left_ff == 5'd1) begin
               active_in = 1'b0;
            end
         end else begin
            rep_in = rep_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         left_ff   <= 5'd0;
         rep_ff    <= 2'd0;
      end else begin
         active_ff <= active_in;
         left_ff   <= left_in;
         rep_ff    <= rep_in;
      end
      halves_ff <= halves_in;
   end

endmodule

>>> src/vsme_out_reg.sv
// Output register that holds one segment until the downstream side takes it.
module vsme_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 seg_valid,
   output logic                 seg_ready,
   input  vsme_pkg::seg_type    seg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vsme_pkg::seg_type    out_seg
);
   import vsme_pkg::*;

   logic    valid_ff, valid_in;
   seg_type seg_ff, seg_in;

   assign seg_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_seg   = seg_ff;

   always_comb begin
      valid_in = valid_ff;
      seg_in   = seg_ff;
      if (seg_ready) begin
         valid_in = seg_valid;
         seg_in   = seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      seg_ff <= seg_in;
   end

endmodule

>>> src/vicc_subcarrier_manchester_encoder.sv
// Top level of the single-subcarrier Manchester encoder for a tag response.
//
// Each request transfer carries a start-of-frame, data-byte or end-of-frame
// command and is turned into a run of 16-slot segments, one segment per
// response transfer, with tlast marking the final segment of the command.
// A frame delimiter gives 8*k segments and a byte 16*k, where k is 1 at the
// high data rate and 4 when low_rate is set. The sequencer produces one
// segment per cycle unless the response side stalls, and a command
// occupies it until its last segment leaves; a new request transfer is
// taken in the cycle after that last segment leaves the sequencer, while
// it may still wait in the output register. The unused command code is taken
// and dropped without a response. The rate register is written through the
// csr channel, which is always ready, and must only change while idle.
module vicc_subcarrier_manchester_encoder (
   input  logic        clock,
   input  logic        reset,
   // Rate register write channel: bit 0 is low_rate.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_data,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] cmd, [9:2] data_byte, [15:10] zero
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] slot_pattern
   output logic        rsp_tlast    // last_segment
);
   import vsme_pkg::*;

   logic        low_rate_ff, low_rate_in;
   cmd_type     cmd;
   logic [7:0]  data_byte;
   logic        busy;
   logic        accept;
   logic        start;
   logic [15:0] halves;
   logic [4:0]  half_count;
   logic        seg_valid, seg_ready;
   seg_type     seg, out_seg;

   assign csr_ready   = 1'b1;
   assign low_rate_in = (csr_valid && csr_ready) ? csr_data[0] : low_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_rate_ff <= 1'b0;
      end else begin
         low_rate_ff <= low_rate_in;
      end
   end

   assign cmd        = cmd_type'(req_tdata[1:0]);
   assign data_byte  = req_tdata[9:2];
   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (cmd != CMD_NONE);

   // Select the half-bit sequence that the command expands into.
   always_comb begin
      case (cmd)
         CMD_SOF: begin
            halves     = SOF_HALVES;
            half_count = FRAME_HALF_COUNT;
         end
         CMD_DATA: begin
            halves     = byte_halves(data_byte);
            half_count = BYTE_HALF_COUNT;
         end
         CMD_EOF: begin
            halves     = EOF_HALVES;
            half_count = FRAME_HALF_COUNT;
         end
         default: begin
            halves     = 16'd0;
            half_count = 5'd0;
         end
      endcase
   end

   vsme_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .low_rate   (low_rate_ff),
      .start      (start),
      .halves     (halves),
      .half_count (half_count),
      .busy       (busy),
      .seg_valid  (seg_valid),
      .seg_ready  (seg_ready),
      .seg        (seg)
   );

   vsme_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (seg_valid),
      .seg_ready (seg_ready),
      .seg       (seg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_seg   (out_seg)
   );

   assign rsp_tdata = out_seg.pattern;
   assign rsp_tlast = out_seg.last;

endmodule

>>> tb/vicc_subcarrier_manchester_encoder_tb.sv
// Self-checking testbench for the single-subcarrier Manchester encoder.
module vicc_subcarrier_manchester_encoder_tb;
   import vsme_pkg::*;

   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 10;
   // Cycles allowed after the last expected segment. This covers the output
   // register and a dropped unused command that may still be in flight.
   localparam int SETTLE_CYCLES  = 16;
   // Long receiver hold-off. It is well beyond anything the block can buffer.
   localparam int HOLD_CYCLES    = 300;
   localparam int TIMEOUT_CYCLES = 10_000_000;
   localparam int PHASE_ITEMS    = 55;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;     // [1:0] cmd, [9:2] data_byte, [15:10] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;     // [15:0] slot_pattern
   logic        rsp_tlast;     // last_segment

   // Predictor state. This mirrors the rate register as the block holds it.
   logic        rate_is_low;
   // Segments that the accepted commands still owe, oldest first.
   seg_type     expected_segments[$];
   int          error_count = 0;
   // When low, the random idle gaps are switched off on both sides.
   bit          gaps_on = 1'b1;
   // The receiver takes this request and clears it when it starts a long hold-off.
   logic        hold_pending = 1'b0;

   vicc_subcarrier_manchester_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // Idle gap length. Most gaps are short, and now and then one is long.
   function automatic int gap_length();
      if ($urandom_range(0, 15) < 13)
         return $urandom_range(0, 3);
      return $urandom_range(12, 60);
   endfunction

   // Builds the segments that one command must produce and queues them. The
   // command is first written as a string of half-bits, where 1 is a
   // subcarrier half and the first half is in bit 0. Each half then becomes
   // k identical segments: k is 1 at the high rate and 4 at the low rate.
   function automatic void predict_segments(input cmd_type cmd, input logic [7:0] data);
      logic [15:0] halves;
      int          half_count;
      int          k;
      seg_type     seg;
      k = rate_is_low ? 4 : 1;
      halves = '0;
      case (cmd)
         CMD_SOF: begin
            // Three silent halves, three subcarrier halves, then a one bit.
            halves     = 16'b0000_0000_1011_1000;
            half_count = 8;
         end
         CMD_DATA: begin
            // The byte goes out LSB first. A one bit is silence, then subcarrier.
            for (int b = 0; b < 8; b++) begin
               halves[2*b]   = !data[b];
               halves[2*b+1] = data[b];
            end
            half_count = 16;
         end
         CMD_EOF: begin
            // A zero bit, three subcarrier halves, then three silent halves.
            halves     = 16'b0000_0000_0001_1101;
            half_count = 8;
         end
         default: return;   // the unused code is taken and dropped
      endcase
      for (int h = 0; h < half_count; h++) begin
         for (int r = 0; r < k; r++) begin
            seg.pattern = halves[h] ? SEG_SUBCARRIER : SEG_SILENCE;
            seg.last    = (h == half_count - 1) && (r == k - 1);
            expected_segments.push_back(seg);
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Offers one command on the request channel after an optional idle gap.
   // tvalid stays high between back-to-back commands. The expected segments
   // are queued at the edge where the transfer happens.
   task automatic send_item(input cmd_type cmd, input logic [7:0] data);
      int gap;
      gap = gaps_on ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, data, cmd};
      do @(posedge clock); while (!req_tready);
      predict_segments(cmd, data);
   endtask

   // Stops offering commands. It waits until every owed segment has arrived,
   // then lets the block settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the rate register. Callers do this only while the block is idle.
   task automatic write_rate(input logic low);
      csr_valid <= 1'b1;
      csr_data  <= low;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      rate_is_low = low;
   endtask

   // Every command, the extreme bytes, the unused code and stray data bytes
   // with the delimiters, at the high rate that reset selects.
   task automatic test_directed_high_rate();
      send_item(CMD_SOF,  8'h00);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'hFF);
      send_item(CMD_DATA, 8'h01);
      send_item(CMD_DATA, 8'h80);
      send_item(CMD_DATA, 8'hA5);
      send_item(CMD_EOF,  8'h00);
      // The unused code carries a full byte and must give nothing.
      send_item(CMD_NONE, 8'hFF);
      // Data bits on the delimiters are ignored.
      send_item(CMD_SOF,  8'hFF);
      send_item(CMD_EOF,  8'h5A);
      // No frame state is kept, so these commands out of order are still encoded.
      send_item(CMD_EOF,  8'h00);
      send_item(CMD_DATA, 8'h3C);
      send_item(CMD_SOF,  8'h00);
      send_item(CMD_SOF,  8'h00);
      wait_drained();
   endtask

   task automatic test_directed_low_rate();
      write_rate(1'b1);
      send_item(CMD_SOF,  8'h00);
      send_item(CMD_DATA, 8'hFF);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_NONE, 8'h00);
      send_item(CMD_DATA, 8'hC3);
      send_item(CMD_EOF,  8'hFF);
      wait_drained();
      write_rate(1'b0);
   endtask

   // The receiver holds off for a long stretch while bytes keep coming with
   // no gaps. The block fills and must stall its request side without
   // losing a segment. The sender then pauses until all owed segments have
   // arrived, and it finishes the frame afterward.
   task automatic test_output_backpressure();
      gaps_on = 1'b0;
      hold_pending <= 1'b1;
      send_item(CMD_SOF, 8'h00);
      repeat (12) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      wait_drained();
      gaps_on = 1'b1;
      repeat (3) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      send_item(CMD_EOF, 8'h00);
      wait_drained();
   endtask

   // Mostly well-formed frames with random bytes. Some frames lack their end
   // of frame, and now and then a short burst of random commands acts as
   // noise. The rate is written before each phase, once the block is idle.
   task automatic test_random_frames();
      int      sent;
      int      byte_count;
      cmd_type noise_cmd;
      for (int phase = 0; phase < 4; phase++) begin
         write_rate(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 6) != 0) begin
               byte_count = $urandom_range(1, 8);
               send_item(CMD_SOF, 8'($urandom_range(0, 255)));
               repeat (byte_count) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
               sent += byte_count + 1;
               if ($urandom_range(0, 9) != 0) begin
                  send_item(CMD_EOF, 8'($urandom_range(0, 255)));
                  sent++;
               end
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  noise_cmd = cmd_type'($urandom_range(0, 3));
                  send_item(noise_cmd, 8'($urandom_range(0, 255)));
                  if (noise_cmd != CMD_NONE)
                     sent++;
               end
            end
         end
         gaps_on = 1'b1;
         wait_drained();
      end
      write_rate(1'b0);
   endtask

   // Receiver pacing. It makes random stalls, and it makes one long counted
   // hold-off when a test asks for it.
   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            stall_left = HOLD_CYCLES;
            hold_pending <= 1'b0;
         end else if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = gap_length();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Each response transfer is compared with the oldest owed segment.
   always @(posedge clock) begin
      seg_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_segments.size() == 0) begin
            report_mismatch($sformatf("unexpected segment %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = expected_segments.pop_front();
            if (rsp_tdata !== want.pattern)
               report_mismatch($sformatf("slot_pattern %h, expected %h",
                                         rsp_tdata, want.pattern));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last_segment %b, expected %b",
                                         rsp_tlast, want.last));
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      csr_valid   <= 1'b0;
      csr_data    <= 1'b0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rate_is_low = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_high_rate();
      test_directed_low_rate();
      test_output_backpressure();
      test_random_frames();
      wait_drained();

      if (error_count == 0)
         $display("vicc_subcarrier_manchester_encoder verification clean");
      else
         $display("vicc_subcarrier_manchester_encoder verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("vicc_subcarrier_manchester_encoder verification failed");
      $finish;
   end

endmodule

>>> sim.f
src/vsme_pkg.sv
src/vsme_sequencer.sv
src/vsme_out_reg.sv
src/vicc_subcarrier_manchester_encoder.sv
tb/vicc_subcarrier_manchester_encoder_tb.sv
